>>> rtl/frn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frn_pkg - shared types and helpers for the fixed-point rsqrt/reciprocal
// Beat structs, per-stage work record and the sign-magnitude multiply.
// ---------------------------------------------------------------------------
package frn_pkg;

  localparam int ITERATIONS_DEF        = 10;
  localparam int FRAC_BITS_DEF         = 16;
  localparam int SEED_STEP_LIMIT       = 32;
  localparam int SEED_STEPS_PER_STAGE  = 4;
  localparam int SEED_STAGES           = SEED_STEP_LIMIT / SEED_STEPS_PER_STAGE;

  // commands
  localparam logic CMD_RSQRT = 1'b0;
  localparam logic CMD_RECIP = 1'b1;

  // Newton step phases
  typedef enum logic [1:0] {
    PH_SQUARE = 2'd0,
    PH_CORR   = 2'd1,
    PH_UPDATE = 2'd2
  } phase_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               invalid;
  } rsp_t;

  // one item in flight; aux is the scratch operand while seeding and the
  // intermediate product/correction term during Newton steps
  typedef struct packed {
    logic        cmd;
    logic        invalid;
    logic        up;
    logic [31:0] k;
    logic [31:0] x;
    logic [31:0] aux;
  } work_t;

  // sign-magnitude multiply, truncated to frac bits, wrapping to 32 bits
  function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b,
                                         input int frac);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] prod;
    logic [63:0] shd;
    neg  = a[31] ^ b[31];
    ma   = a[31] ? (32'd0 - a) : a;
    mb   = b[31] ? (32'd0 - b) : b;
    prod = {32'd0, ma} * {32'd0, mb};
    shd  = prod >> frac;
    return neg ? (32'd0 - shd[31:0]) : shd[31:0];
  endfunction

endpackage

>>> rtl/frn_seed_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frn_seed_stage - power-of-two seed search, a few shift steps per stage
// Shifts the scratch operand toward 1.0 and the seed in the same direction.
// ---------------------------------------------------------------------------
module frn_seed_stage #(
  parameter int FRAC_BITS = frn_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  frn_pkg::work_t in_w,
  output logic           vld,
  output frn_pkg::work_t w
);

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  frn_pkg::work_t w_next;

  always_comb begin
    w_next = in_w;
    for (int s = 0; s < frn_pkg::SEED_STEPS_PER_STAGE; s++) begin
      if (w_next.up) begin
        if (w_next.aux < ONE) begin
          w_next.x   = w_next.x << 1;
          w_next.aux = (w_next.cmd == frn_pkg::CMD_RECIP) ? (w_next.aux << 1)
                                                          : (w_next.aux << 2);
        end
      end else begin
        if (w_next.aux > ONE) begin
          w_next.x   = w_next.x >> 1;
          w_next.aux = (w_next.cmd == frn_pkg::CMD_RECIP) ? (w_next.aux >> 1)
                                                          : (w_next.aux >> 2);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= w_next;
    end
  end

endmodule

>>> rtl/frn_newton_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frn_newton_stage - one multiply of a Newton-Raphson step
// Phase selects which of the three products this stage forms.
// ---------------------------------------------------------------------------
module frn_newton_stage #(
  parameter int              FRAC_BITS = frn_pkg::FRAC_BITS_DEF,
  parameter frn_pkg::phase_t PHASE     = frn_pkg::PH_SQUARE
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  frn_pkg::work_t in_w,
  output logic           vld,
  output frn_pkg::work_t w
);

  localparam logic [31:0] ONE   = 32'(1) << FRAC_BITS;
  localparam logic [31:0] TWO   = ONE << 1;
  localparam logic [31:0] THREE = ONE + TWO;

  frn_pkg::work_t w_next;
  logic [31:0]    ma;
  logic [31:0]    mb;
  logic [31:0]    p;

  always_comb begin
    w_next = in_w;
    unique case (PHASE)
      frn_pkg::PH_SQUARE: begin
        ma = (in_w.cmd == frn_pkg::CMD_RECIP) ? in_w.k : in_w.x;
        mb = in_w.x;
      end
      frn_pkg::PH_CORR: begin
        ma = in_w.k;
        mb = in_w.aux;
      end
      default: begin
        ma = in_w.x;
        mb = in_w.aux;
      end
    endcase
    p = frn_pkg::fx_mul(ma, mb, FRAC_BITS);
    unique case (PHASE)
      frn_pkg::PH_SQUARE: w_next.aux = p;
      frn_pkg::PH_CORR: begin
        w_next.aux = (in_w.cmd == frn_pkg::CMD_RECIP) ? (TWO - in_w.aux) : (THREE - p);
      end
      default: begin
        w_next.x = (in_w.cmd == frn_pkg::CMD_RECIP) ? p : {p[31], p[31:1]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= w_next;
    end
  end

endmodule

>>> rtl/fixed_rsqrt_reciprocal_newton.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_rsqrt_reciprocal_newton - pipelined fixed-point 1/sqrt(k) and 1/k
// Seed search pipeline followed by three multiply stages per Newton step.
// ---------------------------------------------------------------------------
// A new beat can be taken every cycle while the output is not stalled; each
// result passes through the eight seed stages of four shift steps each and the
// three multiply stages (square, correction, update) of every Newton step, one
// 32x32 multiplier per stage. The whole pipe advances together: a stalled
// result holds every stage, and req_ready is low only while the result at the
// output is not taken.
// Zero and negative operands ride through the pipe and leave with invalid set
// and value 0.
module fixed_rsqrt_reciprocal_newton #(
  parameter int ITERATIONS = frn_pkg::ITERATIONS_DEF,
  parameter int FRAC_BITS  = frn_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  frn_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output frn_pkg::rsp_t rsp
);

  localparam int          NSTG = frn_pkg::SEED_STAGES + 3 * ITERATIONS;
  localparam logic [31:0] ONE  = 32'(1) << FRAC_BITS;

  // index 0 is the incoming beat, index i the output of stage i
  logic           vld [NSTG+1];
  frn_pkg::work_t wk  [NSTG+1];
  logic           en;

  // whole pipe moves unless the last stage holds an untaken result
  assign en        = !vld[NSTG] || rsp_ready;
  assign req_ready = en;

  assign vld[0] = req_valid;
  assign wk[0]  = '{cmd:     req.command,
                    invalid: (req.operand == 32'sd0) || req.operand[31],
                    up:      req.operand < ONE,
                    k:       req.operand,
                    x:       ONE,
                    aux:     req.operand};

  for (genvar i = 0; i < frn_pkg::SEED_STAGES; i++) begin : g_seed
    frn_seed_stage #(.FRAC_BITS(FRAC_BITS)) u_seed (
      .clk(clk), .rst(rst), .en(en),
      .in_vld(vld[i]), .in_w(wk[i]),
      .vld(vld[i+1]), .w(wk[i+1])
    );
  end

  for (genvar j = 0; j < 3 * ITERATIONS; j++) begin : g_nr
    localparam int N = frn_pkg::SEED_STAGES + j;
    frn_newton_stage #(
      .FRAC_BITS(FRAC_BITS),
      .PHASE(frn_pkg::phase_t'(j % 3))
    ) u_nr (
      .clk(clk), .rst(rst), .en(en),
      .in_vld(vld[N]), .in_w(wk[N]),
      .vld(vld[N+1]), .w(wk[N+1])
    );
  end

  assign rsp_valid   = vld[NSTG];
  assign rsp.invalid = wk[NSTG].invalid;
  assign rsp.value   = wk[NSTG].invalid ? 32'sd0 : wk[NSTG].x;

  // ---- assertions ----
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.invalid |-> rsp.value == 32'sd0)
    else $error("flagged result carries nonzero value");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[1]) && $stable(vld[NSTG]))
    else $error("pipe moved while stalled");

  a_first_from_req: assert property (@(posedge clk) disable iff (rst)
    $rose(vld[1]) |-> $past(req_valid && req_ready))
    else $error("first stage filled without an accepted beat");

endmodule
